[src/rtr_pkg.sv]
// shared types, widths and codes for the receive reassembly block
package rtr_pkg;

  localparam int TABLE_ENTRIES = 64;
  localparam int BUFFER_BYTES  = 131072;

  localparam int SEQ_W  = 32;
  localparam int LEN_W  = 11;
  localparam int WIN_W  = 18;
  localparam int ST_W   = 3;
  localparam int IDX_W  = $clog2(TABLE_ENTRIES);
  localparam int CNT_W  = $clog2(TABLE_ENTRIES + 1);
  localparam int FILL_W = $clog2(BUFFER_BYTES);
  localparam int SUM_W  = FILL_W + 2;

  localparam logic [ST_W-1:0] ST_IN_ORDER = 3'd0;
  localparam logic [ST_W-1:0] ST_STORED   = 3'd1;
  localparam logic [ST_W-1:0] ST_IGNORED  = 3'd2;
  localparam logic [ST_W-1:0] ST_CORRUPT  = 3'd3;
  localparam logic [ST_W-1:0] ST_FULL     = 3'd4;

  typedef struct packed {
    logic [SEQ_W-1:0] seq;
    logic [LEN_W-1:0] len;
  } entry_t;

endpackage

[src/rtr_table.sv]
// held segment table: one write port, one registered read port
module rtr_table (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [rtr_pkg::IDX_W-1:0]  wr_addr,
  input  rtr_pkg::entry_t            wr_data,
  input  logic                       rd_en,
  input  logic [rtr_pkg::IDX_W-1:0]  rd_addr,
  output rtr_pkg::entry_t            rd_data
);
  import rtr_pkg::*;

  entry_t mem [TABLE_ENTRIES];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[src/rtr_unit.sv]
// shared compare and advance unit: entry match, sequence add, fill add modulo buffer size
module rtr_unit (
  input  logic [rtr_pkg::SEQ_W-1:0]  key,
  input  logic [rtr_pkg::SEQ_W-1:0]  entry_seq,
  input  logic [rtr_pkg::SEQ_W-1:0]  base_seq,
  input  logic [rtr_pkg::LEN_W-1:0]  len,
  input  logic [rtr_pkg::FILL_W-1:0] fill,
  output logic                       match,
  output logic [rtr_pkg::SEQ_W-1:0]  seq_sum,
  output logic [rtr_pkg::FILL_W-1:0] fill_sum
);
  import rtr_pkg::*;

  localparam logic [SUM_W-1:0] BUF1 = SUM_W'(BUFFER_BYTES);
  localparam logic [SUM_W-1:0] BUF2 = SUM_W'(2 * BUFFER_BYTES);

  logic [SUM_W-1:0] raw;
  logic [SUM_W-1:0] wrapped;

  assign match   = (key == entry_seq);
  assign seq_sum = base_seq + SEQ_W'(len);
  assign raw     = SUM_W'(fill) + SUM_W'(len);

  always_comb begin
    if (raw >= BUF2) begin
      wrapped = raw - BUF2;
    end else if (raw >= BUF1) begin
      wrapped = raw - BUF1;
    end else begin
      wrapped = raw;
    end
  end

  assign fill_sum = wrapped[FILL_W-1:0];

endmodule

[src/transport_receive_reassembly.sv]
// top level: header sequencer for receive reassembly with held segment table
// an old or corrupt header, or a later one with end flag, goes from S_IDLE straight to S_DONE
// an in-order or later header goes to S_RD and scans the held table before S_DONE
// (one registered table read and one compare per held entry)
// each drained held segment not in the last slot adds a move (S_MOVE_RD, S_MOVE_WR), then a rescan
// a new header is taken only once the last result is issued; sync reset, table not cleared, only its count
module transport_receive_reassembly (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_wr_en,
  input  logic [rtr_pkg::SEQ_W-1:0]  cfg_wr_data,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [79:0]                s_axis_tdata,  // magic, seq_num, payload_len, zero pad
  input  logic                       s_axis_tlast,  // end_flag
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [55:0]                m_axis_tdata,  // ack_seq, window, status, zero pad
  output logic                       m_axis_tlast   // eof_ack
);
  import rtr_pkg::*;

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_RD      = 3'd1;
  localparam logic [2:0] S_CMP     = 3'd2;
  localparam logic [2:0] S_MOVE_RD = 3'd3;
  localparam logic [2:0] S_MOVE_WR = 3'd4;
  localparam logic [2:0] S_DONE    = 3'd5;

  logic [2:0]       state;
  logic [CNT_W-1:0] idx;
  logic [IDX_W-1:0] pos;
  logic [CNT_W-1:0] count;
  logic [SEQ_W-1:0] next_expected;
  logic [FILL_W-1:0] fill;
  logic [SEQ_W-1:0] expected_magic;
  logic [SEQ_W-1:0] seq_r;
  logic [LEN_W-1:0] len_r;
  logic             end_r;
  logic             drain;
  logic [ST_W-1:0]  status_r;
  logic             eof_r;

  logic [SEQ_W-1:0] in_magic;
  logic [SEQ_W-1:0] in_seq;
  logic [LEN_W-1:0] in_len;
  logic             in_fire;
  logic             scan_end;
  logic             table_full;

  logic             tbl_wr_en;
  logic [IDX_W-1:0] tbl_wr_addr;
  entry_t           tbl_wr_data;
  logic             tbl_rd_en;
  logic [IDX_W-1:0] tbl_rd_addr;
  entry_t           tbl_rd_data;

  logic [SEQ_W-1:0] key;
  logic [LEN_W-1:0] unit_len;
  logic             match;
  logic [SEQ_W-1:0] seq_sum;
  logic [FILL_W-1:0] fill_sum;
  logic [31:0]      win_full;

  assign in_magic = s_axis_tdata[31:0];
  assign in_seq   = s_axis_tdata[63:32];
  assign in_len   = s_axis_tdata[74:64];

  assign s_axis_tready = (state == S_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign scan_end      = (idx == count);
  assign table_full    = (count == CNT_W'(TABLE_ENTRIES));

  assign tbl_wr_en   = ((state == S_RD) && scan_end && !drain && !table_full) ||
                       (state == S_MOVE_WR);
  assign tbl_wr_addr = (state == S_MOVE_WR) ? pos : count[IDX_W-1:0];
  assign tbl_wr_data = (state == S_MOVE_WR) ? tbl_rd_data : entry_t'{seq: seq_r, len: len_r};
  assign tbl_rd_en   = ((state == S_RD) && !scan_end) || (state == S_MOVE_RD);
  assign tbl_rd_addr = (state == S_MOVE_RD) ? count[IDX_W-1:0] : idx[IDX_W-1:0];

  assign key      = drain ? next_expected : seq_r;
  assign unit_len = (state == S_IDLE) ? in_len : tbl_rd_data.len;
  assign win_full = 32'(BUFFER_BYTES) - 32'(fill);

  rtr_table u_table (
    .clk     (clk),
    .wr_en   (tbl_wr_en),
    .wr_addr (tbl_wr_addr),
    .wr_data (tbl_wr_data),
    .rd_en   (tbl_rd_en),
    .rd_addr (tbl_rd_addr),
    .rd_data (tbl_rd_data)
  );

  rtr_unit u_unit (
    .key       (key),
    .entry_seq (tbl_rd_data.seq),
    .base_seq  (next_expected),
    .len       (unit_len),
    .fill      (fill),
    .match     (match),
    .seq_sum   (seq_sum),
    .fill_sum  (fill_sum)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_magic <= '0;
    end else if (cfg_wr_en) begin
      expected_magic <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      idx           <= '0;
      count         <= '0;
      next_expected <= '0;
      fill          <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_fire) begin
            seq_r <= in_seq;
            len_r <= in_len;
            end_r <= s_axis_tlast;
            eof_r <= 1'b0;
            idx   <= '0;
            if (in_magic != expected_magic) begin
              status_r <= ST_CORRUPT;
              state    <= S_DONE;
            end else if (in_seq == next_expected) begin
              next_expected <= seq_sum;
              fill          <= fill_sum;
              drain         <= 1'b1;
              state         <= S_RD;
            end else if ((in_seq > next_expected) && !s_axis_tlast) begin
              drain <= 1'b0;
              state <= S_RD;
            end else begin
              status_r <= ST_IGNORED;
              state    <= S_DONE;
            end
          end
        end
        S_RD: begin
          if (scan_end) begin
            if (drain) begin
              status_r <= ST_IN_ORDER;
              eof_r    <= end_r;
            end else if (table_full) begin
              status_r <= ST_FULL;
            end else begin
              count    <= count + CNT_W'(1);
              status_r <= ST_STORED;
            end
            state <= S_DONE;
          end else begin
            state <= S_CMP;
          end
        end
        S_CMP: begin
          if (match) begin
            if (drain) begin
              next_expected <= seq_sum;
              fill          <= fill_sum;
              count         <= count - CNT_W'(1);
              pos           <= idx[IDX_W-1:0];
              if (idx == count - CNT_W'(1)) begin
                idx   <= '0;
                state <= S_RD;
              end else begin
                state <= S_MOVE_RD;
              end
            end else begin
              status_r <= ST_IGNORED;
              state    <= S_DONE;
            end
          end else begin
            idx   <= idx + CNT_W'(1);
            state <= S_RD;
          end
        end
        S_MOVE_RD: begin
          state <= S_MOVE_WR;
        end
        S_MOVE_WR: begin
          idx   <= '0;
          state <= S_RD;
        end
        S_DONE: begin
          if (!m_axis_tvalid) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= {3'b000, status_r, win_full[WIN_W-1:0], next_expected};
            m_axis_tlast  <= eof_r;
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

[src/rtr_checker.sv]
// port-level checks for the receive reassembly block, bound to the top level
module rtr_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [55:0] m_axis_tdata,
  input logic        m_axis_tlast
);
  import rtr_pkg::*;

  // one header at a time
  a_busy_after: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("ready right after input transfer");

  // eof only on in-order results
  a_eof_in_order: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tlast) |-> (m_axis_tdata[52:50] == ST_IN_ORDER))
    else $error("eof ack without in-order status");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[52:50] <= ST_FULL && m_axis_tdata[55:53] == 3'b000))
    else $error("bad status code or pad bits");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)))
    else $error("stalled result changed");

endmodule

bind transport_receive_reassembly rtr_checker u_rtr_checker (.*);
